@@ rtl/core/uaqn_pkg.sv @@
// Shared constants, job type and fold table for the UTF-8 accent/quote normalizer.
package uaqn_pkg;

  // Byte codes that the classifier looks for
  localparam logic [7:0] LeadLatin  = 8'hC3;
  localparam logic [7:0] LeadPunct  = 8'hE2;
  localparam logic [7:0] MidPunct   = 8'h80;
  localparam logic [7:0] LsqLeft    = 8'h98;
  localparam logic [7:0] LsqRight   = 8'h99;
  localparam logic [7:0] LdqLeft    = 8'h9C;
  localparam logic [7:0] LdqRight   = 8'h9D;
  localparam logic [7:0] AsciiApos  = 8'h27;
  localparam logic [7:0] AsciiDquot = 8'h22;

  // Held-byte counts
  localparam logic [1:0] HeldNone = 2'd0;
  localparam logic [1:0] HeldOne  = 2'd1;
  localparam logic [1:0] HeldTwo  = 2'd2;

  // Largest number of output bytes one input byte can cause
  localparam int unsigned MaxOut = 3;

  // Queue depth between front and back
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // One job: the output bytes caused by one input byte
  typedef struct packed {
    logic [MaxOut-1:0][7:0] bytes;
    logic [1:0]             cnt;   // 1..3, zero-byte jobs are never queued
    logic                   last;  // job belongs to the final input byte
  } job_t;

  // Plain ASCII letter for code point 0xC0 + idx, zero when not a folded letter
  function automatic logic [7:0] fold_letter(input logic [5:0] idx);
    logic [7:0] up;
    begin
      unique case (idx[4:0])
        5'd0, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5: up = 8'h41;       // A
        5'd7:                               up = 8'h43;       // C
        5'd8, 5'd9, 5'd10, 5'd11:           up = 8'h45;       // E
        5'd12, 5'd13, 5'd14, 5'd15:         up = 8'h49;       // I
        5'd17:                              up = 8'h4E;       // N
        5'd18, 5'd19, 5'd20, 5'd21, 5'd22:  up = 8'h4F;       // O
        5'd25, 5'd26, 5'd27, 5'd28:         up = 8'h55;       // U
        5'd29:                              up = 8'h59;       // Y
        5'd31:                              up = idx[5] ? 8'h59 : 8'h00; // y with diaeresis
        default:                            up = 8'h00;
      endcase
      // lower-case half of the block
      fold_letter = (up != 8'h00 && idx[5]) ? (up | 8'h20) : up;
    end
  endfunction

endpackage

@@ rtl/core/uaqn_front.sv @@
// Front end: holds lead bytes, classifies each input byte into an output job.
module uaqn_front import uaqn_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  input  logic       q_full_i,
  output logic       push_o,
  output job_t       job_o
);

  logic [1:0] held_cnt_q, held_cnt_d;
  logic       held_e2_q, held_e2_d;
  logic       accept;

  logic [7:0] ob [MaxOut+1];
  logic [1:0] on;
  logic [7:0] fold_b;
  logic       b_is_lead;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign fold_b     = fold_letter(in_byte_i[5:0]);
  assign b_is_lead  = (in_byte_i == LeadLatin) || (in_byte_i == LeadPunct);

  // Classification: build the output bytes and the next held state
  always_comb begin
    logic fresh;
    fresh      = 1'b0;
    on         = 2'd0;
    held_cnt_d = HeldNone;
    held_e2_d  = held_e2_q;
    for (int i = 0; i <= MaxOut; i++) begin
      ob[i] = 8'h00;
    end

    if (held_cnt_q == HeldOne && !held_e2_q) begin
      if (fold_b != 8'h00) begin
        ob[on] = fold_b;
        on     = on + 2'd1;
      end else begin
        ob[on] = LeadLatin;
        on     = on + 2'd1;
        fresh  = 1'b1;
      end
    end else if (held_cnt_q == HeldOne) begin
      if (in_byte_i == MidPunct) begin
        held_cnt_d = HeldTwo;
      end else begin
        ob[on] = LeadPunct;
        on     = on + 2'd1;
        fresh  = 1'b1;
      end
    end else if (held_cnt_q == HeldTwo) begin
      if (in_byte_i == LsqLeft || in_byte_i == LsqRight) begin
        ob[on] = AsciiApos;
        on     = on + 2'd1;
      end else if (in_byte_i == LdqLeft || in_byte_i == LdqRight) begin
        ob[on] = AsciiDquot;
        on     = on + 2'd1;
      end else begin
        ob[on] = LeadPunct;
        on     = on + 2'd1;
        ob[on] = MidPunct;
        on     = on + 2'd1;
        fresh  = 1'b1;
      end
    end else begin
      fresh = 1'b1;
    end

    // byte examined with nothing held
    if (fresh) begin
      if (b_is_lead) begin
        held_cnt_d = HeldOne;
        held_e2_d  = (in_byte_i == LeadPunct);
      end else begin
        ob[on] = in_byte_i;
        on     = on + 2'd1;
      end
    end

    if (held_cnt_d == HeldNone) begin
      held_e2_d = 1'b0;
    end

    // final byte: flush whatever is still held
    if (in_last_i) begin
      if (held_cnt_d == HeldOne) begin
        ob[on] = held_e2_d ? LeadPunct : LeadLatin;
        on     = on + 2'd1;
      end else if (held_cnt_d == HeldTwo) begin
        ob[on] = LeadPunct;
        on     = on + 2'd1;
        ob[on] = MidPunct;
        on     = on + 2'd1;
      end
      held_cnt_d = HeldNone;
      held_e2_d  = 1'b0;
    end
  end

  // Job toward the queue
  always_comb begin
    for (int i = 0; i < MaxOut; i++) begin
      job_o.bytes[i] = ob[i];
    end
    job_o.cnt  = on;
    job_o.last = in_last_i;
  end

  assign push_o = accept && (on != 2'd0);

  // Held state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_cnt_q <= HeldNone;
      held_e2_q  <= 1'b0;
    end else if (accept) begin
      held_cnt_q <= held_cnt_d;
      held_e2_q  <= held_e2_d;
    end
  end

  // The unused held count never appears
  a_held_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_cnt_q != 2'd3)
    else $error("held count out of range");

  // A final byte leaves nothing held
  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_last_i |=> held_cnt_q == HeldNone && !held_e2_q)
    else $error("held bytes survive the final byte");

endmodule

@@ rtl/core/uaqn_queue.sv @@
// Short job queue between the front end and the back end.
module uaqn_queue import uaqn_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t push_job_i,
  output logic full_o,
  input  logic pop_i,
  output logic head_valid_o,
  output job_t head_job_o
);

  job_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o       = (cnt_q == QCntW'(QDepth));
  assign head_valid_o = (cnt_q != '0);
  assign head_job_o   = mem_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // A push is never dropped
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("job pushed into a full queue");

endmodule

@@ rtl/core/uaqn_back.sv @@
// Back end: serializes queued jobs into output bytes through an output register.
module uaqn_back import uaqn_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       head_valid_i,
  input  job_t       head_job_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       run_last_o,
  output logic       text_end_o
);

  logic [1:0] idx_q, idx_d;
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q, out_byte_d;
  logic       run_last_q, run_last_d;
  logic       text_end_q, text_end_d;
  logic       load, final_b;

  assign load    = head_valid_i && (!out_valid_q || out_ready_i);
  assign final_b = (idx_q == 2'(head_job_i.cnt - 2'd1));
  assign pop_o   = load && final_b;

  // Byte select and next output
  always_comb begin
    unique case (idx_q)
      2'd0:    out_byte_d = head_job_i.bytes[0];
      2'd1:    out_byte_d = head_job_i.bytes[1];
      default: out_byte_d = head_job_i.bytes[2];
    endcase
    run_last_d = final_b;
    text_end_d = final_b && head_job_i.last;
    idx_d      = idx_q;
    if (load) begin
      idx_d = final_b ? 2'd0 : idx_q + 2'd1;
    end
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_byte_q <= out_byte_d;
      run_last_q <= run_last_d;
      text_end_q <= text_end_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign run_last_o  = run_last_q;
  assign text_end_o  = text_end_q;

  // Byte index stays inside the current job
  a_idx_in_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_valid_i |-> idx_q < head_job_i.cnt)
    else $error("byte index past end of job");

  // End of text only on the last byte of a run
  a_end_is_run_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && text_end_o |-> run_last_o)
    else $error("text end without run last");

endmodule

@@ rtl/core/utf8_accent_quote_normalizer_core.sv @@
// Top level of the UTF-8 accent and curly-quote normalizer.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------------
//  in      | input     | in_valid_i/in_ready_o  | in_byte_i, in_last_i
//  out     | output    | out_valid_o/out_ready_i| out_byte_o, run_last_o, text_end_o
//
// One input byte is taken per cycle while the queue is not full; its output bytes pass
// through the job queue and then the output register. Output runs at one byte per cycle
// while out_ready_i is high; a byte that flushes held bytes gives up to three results.
// The two-entry job queue absorbs such runs; input stalls only when it is full.
// Reset clears the held lead bytes, the queue pointers and count and the output valid flag.
module utf8_accent_quote_normalizer_core import uaqn_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       run_last_o,
  output logic       text_end_o
);

  logic push, q_full, pop, head_valid;
  job_t push_job, head_job;

  // Classifier with held lead bytes
  uaqn_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_byte_i  (in_byte_i),
    .in_last_i  (in_last_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .job_o      (push_job)
  );

  // Job queue
  uaqn_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_job_i   (push_job),
    .full_o       (q_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_job_o   (head_job)
  );

  // Serializer and output register
  uaqn_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_job_i   (head_job),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_o   (out_byte_o),
    .run_last_o   (run_last_o),
    .text_end_o   (text_end_o)
  );

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the UTF-8 accent and curly-quote normalizer core.
module testbench;
  import uaqn_pkg::*;

  localparam int unsigned RandomItems = 400;
  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned DrainCycles = 16;
  localparam int unsigned MaxReports  = 10;

  // One expected output transaction
  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       text_end;
  } out_beat_t;

  // One input transaction
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } in_beat_t;

  // Folding predictor plus queue of expected output bytes
  class fold_scoreboard;
    logic [7:0]  fold_lut [64];
    logic [1:0]  held_cnt;
    logic        held_e2;
    logic [7:0]  run_buf [$];
    out_beat_t   expected_bytes [$];
    int unsigned mismatches;
    int unsigned bytes_in;
    int unsigned bytes_out;
    int unsigned texts;

    function new();
      // plain letter for code point 0xC0 + index, zero where nothing folds
      fold_lut = '{
        8'h41, 8'h41, 8'h41, 8'h41, 8'h41, 8'h41, 8'h00, 8'h43,
        8'h45, 8'h45, 8'h45, 8'h45, 8'h49, 8'h49, 8'h49, 8'h49,
        8'h00, 8'h4E, 8'h4F, 8'h4F, 8'h4F, 8'h4F, 8'h4F, 8'h00,
        8'h00, 8'h55, 8'h55, 8'h55, 8'h55, 8'h59, 8'h00, 8'h00,
        8'h61, 8'h61, 8'h61, 8'h61, 8'h61, 8'h61, 8'h00, 8'h63,
        8'h65, 8'h65, 8'h65, 8'h65, 8'h69, 8'h69, 8'h69, 8'h69,
        8'h00, 8'h6E, 8'h6F, 8'h6F, 8'h6F, 8'h6F, 8'h6F, 8'h00,
        8'h00, 8'h75, 8'h75, 8'h75, 8'h75, 8'h79, 8'h00, 8'h79
      };
      held_cnt   = HeldNone;
      held_e2    = 1'b0;
      mismatches = 0;
      bytes_in   = 0;
      bytes_out  = 0;
      texts      = 0;
    endfunction

    // Append one byte to the run of the current input transaction
    function void add_run_byte(logic [7:0] b);
      run_buf.insert(run_buf.size(), b);
    endfunction

    // A byte seen with nothing held: it either starts a lead or passes
    function void start_fresh(logic [7:0] b);
      if (b == LeadLatin) begin
        held_cnt = HeldOne;
        held_e2  = 1'b0;
      end else if (b == LeadPunct) begin
        held_cnt = HeldOne;
        held_e2  = 1'b1;
      end else begin
        add_run_byte(b);
      end
    endfunction

    // Accepted input transaction: predict the output run it causes
    function void note_input_byte(logic [7:0] b, logic last);
      logic [1:0] prev_cnt;
      logic [7:0] letter;
      out_beat_t  beat;
      prev_cnt = held_cnt;
      run_buf.delete();
      held_cnt = HeldNone;
      bytes_in++;

      if (prev_cnt == HeldOne && !held_e2) begin
        letter = fold_lut[b[5:0]];
        if (letter != 8'h00) begin
          add_run_byte(letter);
        end else begin
          add_run_byte(LeadLatin);
          start_fresh(b);
        end
      end else if (prev_cnt == HeldOne) begin
        if (b == MidPunct) begin
          held_cnt = HeldTwo;
        end else begin
          add_run_byte(LeadPunct);
          start_fresh(b);
        end
      end else if (prev_cnt == HeldTwo) begin
        if (b == LsqLeft || b == LsqRight) begin
          add_run_byte(AsciiApos);
        end else if (b == LdqLeft || b == LdqRight) begin
          add_run_byte(AsciiDquot);
        end else begin
          add_run_byte(LeadPunct);
          add_run_byte(MidPunct);
          start_fresh(b);
        end
      end else begin
        start_fresh(b);
      end

      if (held_cnt == HeldNone) held_e2 = 1'b0;

      // end of text: flush whatever is still held
      if (last) begin
        if (held_cnt == HeldOne) begin
          add_run_byte(held_e2 ? LeadPunct : LeadLatin);
        end else if (held_cnt == HeldTwo) begin
          add_run_byte(LeadPunct);
          add_run_byte(MidPunct);
        end
        held_cnt = HeldNone;
        held_e2  = 1'b0;
        texts++;
      end

      foreach (run_buf[k]) begin
        beat.data     = run_buf[k];
        beat.run_last = (k == run_buf.size() - 1);
        beat.text_end = beat.run_last && last;
        expected_bytes.insert(expected_bytes.size(), beat);
      end
    endfunction

    // Accepted output transaction: compare with the oldest expectation
    function void check_result(logic [7:0] b, logic run_last, logic text_end);
      out_beat_t want;
      bytes_out++;
      if (expected_bytes.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("unexpected output byte %02h run_last %0b text_end %0b",
                   b, run_last, text_end);
      end else begin
        want = expected_bytes.pop_front();
        if (want.data !== b || want.run_last !== run_last || want.text_end !== text_end) begin
          mismatches++;
          if (mismatches <= MaxReports)
            $display("mismatch: expected %02h/%0b/%0b, got %02h/%0b/%0b",
                     want.data, want.run_last, want.text_end, b, run_last, text_end);
        end
      end
    endfunction

    function int unsigned pending();
      return expected_bytes.size();
    endfunction
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [7:0] in_byte_i = 8'h00;
  logic       in_last_i = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [7:0] out_byte_o;
  logic       run_last_o;
  logic       text_end_o;

  logic        calm = 1'b0;  // no idling on either side while set
  int unsigned stall_cycles = 0;
  fold_scoreboard sb = new();

  utf8_accent_quote_normalizer_core i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_byte_i  (in_byte_i),
    .in_last_i  (in_last_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_byte_o (out_byte_o),
    .run_last_o (run_last_o),
    .text_end_o (text_end_o)
  );

  // Clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Receiver back-pressure
  always @(posedge clk_i) begin
    out_ready_i <= calm || ($urandom_range(0, 99) >= 25);
  end

  // Output monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_byte_o, run_last_o, text_end_o);
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= StallLimit) begin
        $display("testbench failed");
        $finish;
      end
    end
  end

  // Drive one input transaction, with an optional idle gap first
  task automatic send_byte(logic [7:0] b, logic last);
    if (!calm && $urandom_range(0, 99) < 25) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    in_last_i  <= last;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input_byte(b, last);
  endtask

  // Append one non-final byte to a text
  function automatic void add_item(ref in_beat_t items [$], input logic [7:0] data);
    items.insert(items.size(), in_beat_t'{data, 1'b0});
  endfunction

  // Append one random token: mostly well-formed sequences, some noise
  function automatic void add_token(ref in_beat_t items [$]);
    int unsigned pick;
    logic [7:0]  tail;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      add_item(items, 8'($urandom_range(8'h20, 8'h7E)));
    end else if (pick < 55) begin
      add_item(items, LeadLatin);
      if ($urandom_range(0, 9) == 0) tail = 8'($urandom_range(0, 255));
      else tail = 8'($urandom_range(8'h80, 8'hBF));
      add_item(items, tail);
    end else if (pick < 75) begin
      add_item(items, LeadPunct);
      add_item(items, MidPunct);
      case ($urandom_range(0, 3))
        0:       tail = LsqLeft;
        1:       tail = LsqRight;
        2:       tail = LdqLeft;
        default: tail = LdqRight;
      endcase
      add_item(items, tail);
    end else if (pick < 83) begin
      add_item(items, LeadPunct);
      add_item(items, MidPunct);
      add_item(items, 8'($urandom_range(0, 255)));
    end else if (pick < 89) begin
      add_item(items, LeadPunct);
      add_item(items, 8'($urandom_range(0, 255)));
    end else begin
      add_item(items, 8'($urandom_range(0, 255)));
    end
  endfunction

  initial begin
    in_beat_t    items [$];
    int unsigned sent;
    int unsigned ntok;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: byte extremes, folds, misses, quotes and flushes at text end
    items = '{
      '{8'h00, 1'b0}, '{8'hFF, 1'b1},
      '{LeadLatin, 1'b0}, '{8'h80, 1'b0},           // A
      '{LeadLatin, 1'b0}, '{8'hBF, 1'b0},           // y with diaeresis
      '{LeadLatin, 1'b0}, '{8'h86, 1'b0},           // no fold: lead is passed on
      '{LeadLatin, 1'b0}, '{8'h00, 1'b0},           // non-continuation second byte
      '{LeadPunct, 1'b0}, '{MidPunct, 1'b0}, '{LsqLeft, 1'b0},
      '{LeadPunct, 1'b0}, '{MidPunct, 1'b0}, '{LdqRight, 1'b0},
      '{LeadPunct, 1'b0}, '{8'h41, 1'b0},
      '{LeadPunct, 1'b0}, '{MidPunct, 1'b0}, '{8'h41, 1'b0},
      '{LeadPunct, 1'b0}, '{MidPunct, 1'b0}, '{LeadLatin, 1'b1},
      '{LeadLatin, 1'b1},
      '{LeadPunct, 1'b0}, '{MidPunct, 1'b1}
    };
    foreach (items[i]) send_byte(items[i].data, items[i].last);

    // Random texts of a few tokens each
    sent = 0;
    while (sent < RandomItems) begin
      items.delete();
      ntok = $urandom_range(1, 12);
      repeat (ntok) add_token(items);
      items[items.size() - 1].last = 1'b1;
      foreach (items[i]) begin
        calm <= (sent >= 150 && sent < 250);
        send_byte(items[i].data, items[i].last);
        sent++;
      end
    end
    calm       <= 1'b0;
    in_valid_i <= 1'b0;

    // Drain and settle
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("ran %0d input bytes in %0d texts, checked %0d output bytes, %0d mismatches",
             sb.bytes_in, sb.texts, sb.bytes_out, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
